// ===== hdl/dmtp_pkg.sv =====
// ----------------------------------------------------------------------------
// Dot matrix transition pixel package
// Matrix geometry, effect codes, shared types and the phase reduction helper.
// ----------------------------------------------------------------------------
`default_nettype none

package dmtp_pkg;

    localparam int ROWS        = 24;
    localparam int COLS        = 48;
    localparam int HALF        = ROWS / 2;
    localparam int NUM_EFFECTS = 20;

    localparam int RW    = $clog2(ROWS);
    localparam int XW    = $clog2(COLS);
    localparam int AW    = $clog2(ROWS * COLS);
    localparam int PW    = $clog2(COLS);
    localparam int CRD_W = $clog2(3 * COLS + 64) + 1;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_RENDER = 1'b1;

    typedef enum logic [4:0] {
        EFF_SLIDE_IN_R    = 5'd0,
        EFF_SLIDE_OUT_L   = 5'd1,
        EFF_ROT_L         = 5'd2,
        EFF_ROT_R         = 5'd3,
        EFF_OPEN_H        = 5'd4,
        EFF_CLOSE_H       = 5'd5,
        EFF_SMEAR_R       = 5'd6,
        EFF_SMEAR_L       = 5'd7,
        EFF_STRETCH_R     = 5'd8,
        EFF_STRETCH_L     = 5'd9,
        EFF_WIPE_DOWN     = 5'd10,
        EFF_WIPE_UP       = 5'd11,
        EFF_SLIDE_DOWN    = 5'd12,
        EFF_SLIDE_UP      = 5'd13,
        EFF_OPEN_V        = 5'd14,
        EFF_CLOSE_V       = 5'd15,
        EFF_STRETCH_DOWN  = 5'd16,
        EFF_STRETCH_UP    = 5'd17,
        EFF_CHECKER_DOWN  = 5'd18,
        EFF_CHECKER_UP    = 5'd19
    } t_effect;

    typedef logic signed [CRD_W-1:0] t_crd;

    // Source coordinate of a pixel and whether the source bit is shown at all.
    typedef struct packed {
        logic          ok;
        logic [RW-1:0] sy;
        logic [XW-1:0] sx;
    } t_src;

    // Remainder of a 6-bit value by a constant divisor, as restoring steps.
    function automatic logic [5:0] f_mod(input logic [5:0] v, input int d);
        logic [5:0] r;
        r = v;
        for (int k = 5; k >= 0; k--) begin
            if (int'(r) >= (d << k)) begin
                r = r - 6'(d << k);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dmtp_addr.sv =====
// ----------------------------------------------------------------------------
// Dot matrix transition pixel source address unit
// Maps effect, reduced phase and pixel coordinate to the source pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module dmtp_addr (
    input  wire logic                 i_mode,
    input  wire dmtp_pkg::t_effect    i_effect,
    input  wire logic [dmtp_pkg::PW-1:0] i_p,
    input  wire logic [5:0]           i_col,
    input  wire logic [4:0]           i_row,
    output dmtp_pkg::t_src            o_src
);

    localparam dmtp_pkg::t_crd C_COLS = dmtp_pkg::t_crd'(dmtp_pkg::COLS);
    localparam dmtp_pkg::t_crd C_ROWS = dmtp_pkg::t_crd'(dmtp_pkg::ROWS);
    localparam dmtp_pkg::t_crd C_HALF = dmtp_pkg::t_crd'(dmtp_pkg::HALF);
    localparam dmtp_pkg::t_crd C_ONE  = dmtp_pkg::t_crd'(1);
    localparam dmtp_pkg::t_crd C_TWO  = dmtp_pkg::t_crd'(2);

    dmtp_pkg::t_crd x;
    dmtp_pkg::t_crd y;
    dmtp_pkg::t_crd p;
    dmtp_pkg::t_crd s;
    dmtp_pkg::t_crd sx;
    dmtp_pkg::t_crd sy;
    logic           dark;
    logic           chk;
    logic           in_matrix;
    logic           in_range;

    always_comb begin
        x    = dmtp_pkg::t_crd'(i_col);
        y    = dmtp_pkg::t_crd'(i_row);
        p    = dmtp_pkg::t_crd'(i_p);
        s    = '0;
        sx   = x;
        sy   = y;
        dark = 1'b0;
        chk  = 1'b1;
        if (i_mode == dmtp_pkg::MODE_RENDER) begin
            unique case (i_effect)
                dmtp_pkg::EFF_SLIDE_OUT_L: begin
                    if (x < p) sx = C_COLS - p + x - C_ONE;
                    else dark = 1'b1;
                end
                dmtp_pkg::EFF_ROT_L: begin
                    sx = x + p;
                    if (sx >= C_COLS) sx = sx - C_COLS;
                end
                dmtp_pkg::EFF_ROT_R: begin
                    sx = x - p - C_ONE;
                    if (sx < 0) sx = sx + C_COLS;
                end
                dmtp_pkg::EFF_OPEN_H: begin
                    dark = (x < C_ROWS - p) || (x > C_ROWS + p);
                end
                dmtp_pkg::EFF_CLOSE_H: begin
                    dark = !((x < p + C_ONE) || (x > C_TWO * C_ROWS - p - C_ONE));
                end
                dmtp_pkg::EFF_SMEAR_R: begin
                    if (x >= p) sx = p;
                end
                dmtp_pkg::EFF_SMEAR_L: begin
                    s = C_COLS - p;
                    if (x < s) sx = s - C_ONE;
                end
                dmtp_pkg::EFF_STRETCH_R: begin
                    if (x >= p) sx = p + ((x - p) >>> 1);
                end
                dmtp_pkg::EFF_STRETCH_L: begin
                    s = C_COLS - p;
                    if (x < s) sx = p + ((s - x) >>> 1);
                end
                dmtp_pkg::EFF_WIPE_DOWN: begin
                    dark = !(y < p);
                end
                dmtp_pkg::EFF_WIPE_UP: begin
                    dark = y < C_ROWS - p;
                end
                dmtp_pkg::EFF_SLIDE_DOWN: begin
                    if (y < p) sy = y + C_ROWS - p;
                    else dark = 1'b1;
                end
                dmtp_pkg::EFF_SLIDE_UP: begin
                    s = C_ROWS - p;
                    if (y < s) dark = 1'b1;
                    else sy = y - s;
                end
                dmtp_pkg::EFF_OPEN_V: begin
                    dark = (y < C_HALF - p) || (y > C_HALF + p);
                end
                dmtp_pkg::EFF_CLOSE_V: begin
                    dark = !((y < p + C_ONE) || (y > C_TWO * C_HALF - p - C_TWO));
                end
                dmtp_pkg::EFF_STRETCH_DOWN, dmtp_pkg::EFF_CHECKER_DOWN: begin
                    if (y >= p) begin
                        sy = p + ((y - p) >>> 1);
                        if (i_effect == dmtp_pkg::EFF_CHECKER_DOWN) chk = sy[0] != x[0];
                    end
                end
                dmtp_pkg::EFF_STRETCH_UP, dmtp_pkg::EFF_CHECKER_UP: begin
                    s = C_ROWS - p;
                    if (y < s) begin
                        sy = p + ((s - y) >>> 1);
                        if (i_effect == dmtp_pkg::EFF_CHECKER_UP) chk = sy[0] != x[0];
                    end
                end
                default: begin
                    // Slide in from the right; also taken by unknown effect codes.
                    s = C_COLS - p;
                    if (x < s) dark = 1'b1;
                    else sx = x - s;
                end
            endcase
        end
    end

    assign in_matrix = (int'(i_col) < dmtp_pkg::COLS) && (int'(i_row) < dmtp_pkg::ROWS);
    assign in_range  = (sx >= 0) && (sx < C_COLS) && (sy >= 0) && (sy < C_ROWS);

    assign o_src.ok = in_matrix && in_range && !dark && chk;
    assign o_src.sy = sy[dmtp_pkg::RW-1:0];
    assign o_src.sx = sx[dmtp_pkg::XW-1:0];

endmodule

`default_nettype wire

// ===== hdl/dot_matrix_transition_pixel_top.sv =====
// ----------------------------------------------------------------------------
// Dot matrix transition pixel
// Source image store and per-pixel transition effect renderer.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle and busy never rises. A render result
// is on o_valid/o_pixel_on for exactly one cycle and is taken once the item
// has passed the registers listed below; load items produce no result. The receiver
// cannot stall, and since the pipeline never waits, no result is held back.
// An item passes four registers: the input register, the reduced phase, the
// source address, and the registered read data of the single read/write port
// of the image memory. Loads write the memory in the same stage in which
// renders read it, so items see the image in transfer order without
// forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module dot_matrix_transition_pixel_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       i_mode,
    input  wire logic [4:0] i_effect,
    input  wire logic [5:0] i_phase,
    input  wire logic [5:0] i_col,
    input  wire logic [4:0] i_row,
    input  wire logic       i_pixel_in,
    output logic            o_valid,
    output logic            o_pixel_on
);

    // Stage 1: captured item.
    logic                       r_s1_vld;
    logic                       r_s1_mode;
    logic [4:0]                 r_s1_effect;
    logic [5:0]                 r_s1_phase;
    logic [5:0]                 r_s1_col;
    logic [4:0]                 r_s1_row;
    logic                       r_s1_pix;

    // Stage 2: reduced phase.
    logic                       r_s2_vld;
    logic                       r_s2_mode;
    dmtp_pkg::t_effect          r_s2_effect;
    logic [dmtp_pkg::PW-1:0]    r_s2_p;
    logic [5:0]                 r_s2_col;
    logic [4:0]                 r_s2_row;
    logic                       r_s2_pix;

    // Stage 3: source address.
    logic                       r_s3_vld;
    logic                       r_s3_mode;
    dmtp_pkg::t_src             r_s3_src;
    logic                       r_s3_pix;

    // Stage 4: memory read data.
    logic                       r_s4_vld;
    logic                       r_s4_mode;
    logic                       r_s4_ok;
    logic                       r_rd;

    dmtp_pkg::t_effect          n_s2_effect;
    logic [dmtp_pkg::PW-1:0]    n_s2_p;
    dmtp_pkg::t_src             n_s3_src;
    logic [dmtp_pkg::AW-1:0]    mem_idx;

    logic mem [dmtp_pkg::ROWS * dmtp_pkg::COLS];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    // Effect codes past the last one behave as the slide in from the right.
    always_comb begin
        if (int'(r_s1_effect) >= dmtp_pkg::NUM_EFFECTS) begin
            n_s2_effect = dmtp_pkg::EFF_SLIDE_IN_R;
        end else begin
            n_s2_effect = dmtp_pkg::t_effect'(r_s1_effect);
        end
        unique case (n_s2_effect)
            dmtp_pkg::EFF_SLIDE_IN_R, dmtp_pkg::EFF_SLIDE_OUT_L,
            dmtp_pkg::EFF_ROT_L, dmtp_pkg::EFF_ROT_R,
            dmtp_pkg::EFF_SMEAR_R, dmtp_pkg::EFF_SMEAR_L,
            dmtp_pkg::EFF_STRETCH_R, dmtp_pkg::EFF_STRETCH_L: begin
                n_s2_p = dmtp_pkg::PW'(dmtp_pkg::f_mod(r_s1_phase, dmtp_pkg::COLS));
            end
            dmtp_pkg::EFF_OPEN_V, dmtp_pkg::EFF_CLOSE_V: begin
                n_s2_p = dmtp_pkg::PW'(dmtp_pkg::f_mod(r_s1_phase, dmtp_pkg::HALF));
            end
            default: begin
                n_s2_p = dmtp_pkg::PW'(dmtp_pkg::f_mod(r_s1_phase, dmtp_pkg::ROWS));
            end
        endcase
    end

    dmtp_addr u_addr (
        .i_mode   (r_s2_mode),
        .i_effect (r_s2_effect),
        .i_p      (r_s2_p),
        .i_col    (r_s2_col),
        .i_row    (r_s2_row),
        .o_src    (n_s3_src)
    );

    assign mem_idx = dmtp_pkg::AW'(r_s3_src.sy) * dmtp_pkg::AW'(dmtp_pkg::COLS)
                   + dmtp_pkg::AW'(r_s3_src.sx);

    always_ff @(posedge i_clk) begin
        r_s1_mode   <= i_mode;
        r_s1_effect <= i_effect;
        r_s1_phase  <= i_phase;
        r_s1_col    <= i_col;
        r_s1_row    <= i_row;
        r_s1_pix    <= i_pixel_in;

        r_s2_mode   <= r_s1_mode;
        r_s2_effect <= n_s2_effect;
        r_s2_p      <= n_s2_p;
        r_s2_col    <= r_s1_col;
        r_s2_row    <= r_s1_row;
        r_s2_pix    <= r_s1_pix;

        r_s3_mode   <= r_s2_mode;
        r_s3_src    <= n_s3_src;
        r_s3_pix    <= r_s2_pix;

        r_s4_mode   <= r_s3_mode;
        r_s4_ok     <= r_s3_src.ok;
    end

    // Image memory: one port; every item reads it, and a load with a valid source also writes it.
    always_ff @(posedge i_clk) begin
        if (r_s3_vld && r_s3_mode == dmtp_pkg::MODE_LOAD && r_s3_src.ok) begin
            mem[mem_idx] <= r_s3_pix;
        end
        r_rd <= mem[mem_idx];
    end

    assign o_valid    = r_s4_vld && (r_s4_mode == dmtp_pkg::MODE_RENDER);
    assign o_pixel_on = o_valid && r_s4_ok && r_rd;

endmodule

`default_nettype wire

// ===== hdl/dmtp_chk.sv =====
// ----------------------------------------------------------------------------
// Dot matrix transition pixel port checker
// Watches the top level ports for result timing and blanking rules.
// ----------------------------------------------------------------------------
`default_nettype none

module dmtp_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       i_mode,
    input wire logic [5:0] i_col,
    input wire logic [4:0] i_row,
    input wire logic       o_valid,
    input wire logic       o_pixel_on
);

    logic render_xfer;
    logic outside;

    assign render_xfer = start && !busy && i_mode == dmtp_pkg::MODE_RENDER;
    assign outside     = (int'(i_col) >= dmtp_pkg::COLS) || (int'(i_row) >= dmtp_pkg::ROWS);

    // The block never holds off the sender.
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // Every result comes from an earlier render transfer, with reset released throughout.
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(render_xfer, 4)
                     && $past(i_rst_n, 4) && $past(i_rst_n, 3)
                     && $past(i_rst_n, 2) && $past(i_rst_n, 1)))
        else $error("result without a render transfer");

    // Every render transfer gives its result.
    a_render_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(render_xfer, 4)
         && $past(i_rst_n, 4) && $past(i_rst_n, 3)
         && $past(i_rst_n, 2) && $past(i_rst_n, 1)) |-> o_valid)
        else $error("render transfer lost");

    // A pixel outside the matrix is always dark.
    a_outside_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(render_xfer && outside, 4)
         && $past(i_rst_n, 4) && $past(i_rst_n, 3)
         && $past(i_rst_n, 2) && $past(i_rst_n, 1)) |-> !o_pixel_on)
        else $error("pixel outside the matrix lit");

    // A lit pixel is only shown together with the strobe.
    a_lit_with_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pixel_on |-> o_valid)
        else $error("pixel lit without strobe");

endmodule

bind dot_matrix_transition_pixel_top dmtp_chk u_dmtp_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_mode     (i_mode),
    .i_col      (i_col),
    .i_row      (i_row),
    .o_valid    (o_valid),
    .o_pixel_on (o_pixel_on)
);

`default_nettype wire
